// File: hdl/fol_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fol_pkg
// Shared types and constants for the frequency-ordered list core.
// ----------------------------------------------------------------------------
package fol_pkg;

  localparam int DEPTH_DEF      = 32;
  localparam int VALUE_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF = 16;
  localparam int POS_W          = 6;
  localparam int ORDER_W        = 7;
  localparam int STAMP_W        = 6;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_LOCATE = 2'd1,
    OP_DUMP   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic exec;
    logic dump;
  } fol_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic dump_done;
  } fol_sts_t;

endpackage
`default_nettype wire

// File: hdl/frequency_ordered_list_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frequency_ordered_list_core
// Table of values kept in order of access count, with load, locate, dump
// and clear commands.
// ----------------------------------------------------------------------------
// Load, locate, clear: one result beat, registered in the execute state after
//   accept; busy only in that state, so the next command waits for it (match
//   search on accept, insertion search and shift in the execute cycle).
// Dump: one beat per entry on consecutive cycles, one entry read per cycle;
//   busy until the last entry is read, or for the lone beat of an empty table.
// Reset: table empty and idle at once; no clearing pass. Results cannot stall.
module frequency_ordered_list_core #(
  parameter int DEPTH      = fol_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = fol_pkg::VALUE_BITS_DEF,
  parameter int COUNT_BITS = fol_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  fol_pkg::op_t                  in_op,
  input  logic signed [VALUE_BITS-1:0]  in_value,
  output logic                          out_valid,
  output fol_pkg::status_t              out_status,
  output logic signed [VALUE_BITS-1:0]  out_item_value,
  output logic [COUNT_BITS-1:0]         out_access_count,
  output logic [fol_pkg::POS_W-1:0]     out_position,
  output logic                          out_last
);
  import fol_pkg::*;

  fol_cmd_t cmd;
  fol_sts_t sts;

  fol_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_op),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  fol_datapath #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_op            (in_op),
    .in_value         (in_value),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_item_value   (out_item_value),
    .out_access_count (out_access_count),
    .out_position     (out_position),
    .out_last         (out_last)
  );

endmodule
`default_nettype wire

// File: hdl/fol_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fol_ctrl
// Sequencer: accepts a command, runs one execute cycle or a dump sweep.
// ----------------------------------------------------------------------------
module fol_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  fol_pkg::op_t     in_op,
  input  fol_pkg::fol_sts_t sts,
  output fol_pkg::fol_cmd_t cmd,
  output logic             busy
);
  import fol_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DUMP = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd.accept = 1'b0;
    cmd.exec   = 1'b0;
    cmd.dump   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_nxt  = (in_op == OP_DUMP) ? S_DUMP : S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_DUMP: begin
        cmd.dump = 1'b1;
        if (sts.dump_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule
`default_nettype wire

// File: hdl/fol_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fol_datapath
// Entry registers, parallel match and insertion search, shift, result regs.
// ----------------------------------------------------------------------------
module fol_datapath #(
  parameter int DEPTH      = fol_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = fol_pkg::VALUE_BITS_DEF,
  parameter int COUNT_BITS = fol_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fol_pkg::op_t                  in_op,
  input  logic signed [VALUE_BITS-1:0]  in_value,
  input  fol_pkg::fol_cmd_t             cmd,
  output fol_pkg::fol_sts_t             sts,
  output logic                          out_valid,
  output fol_pkg::status_t              out_status,
  output logic signed [VALUE_BITS-1:0]  out_item_value,
  output logic [COUNT_BITS-1:0]         out_access_count,
  output logic [fol_pkg::POS_W-1:0]     out_position,
  output logic                          out_last
);
  import fol_pkg::*;

  localparam int IDX_W  = $clog2(DEPTH);
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [ORDER_W-1:0]    ORD_MAX = {ORDER_W{1'b1}};

  logic [VALUE_BITS-1:0] val_r [DEPTH];
  logic [COUNT_BITS-1:0] cnt_r [DEPTH];
  logic [STAMP_W-1:0]    ord_r [DEPTH];

  logic [FILL_W-1:0]     fill_r;
  logic [ORDER_W-1:0]    next_ord_r;
  op_t                   op_r;
  logic [VALUE_BITS-1:0] key_r;
  logic                  found_r;
  logic [IDX_W-1:0]      hit_r;
  logic [COUNT_BITS-1:0] cnt_new_r;
  logic [STAMP_W-1:0]    ord_new_r;
  logic                  stamp_r;
  logic [IDX_W-1:0]      dump_idx_r;

  logic                  out_valid_r;
  status_t               status_r;
  logic [VALUE_BITS-1:0] item_r;
  logic [COUNT_BITS-1:0] count_r;
  logic [POS_W-1:0]      pos_r;
  logic                  last_r;

  logic                  hit_any;
  logic [IDX_W-1:0]      hit_idx;
  logic [IDX_W-1:0]      rd_idx;
  logic [VALUE_BITS-1:0] rd_val;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic [STAMP_W-1:0]    rd_ord;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [STAMP_W-1:0]    ord_sel;
  logic [IDX_W-1:0]      dest;
  logic                  full;
  logic                  empty;

  assign full  = (fill_r == FILL_W'(DEPTH));
  assign empty = (fill_r == '0);

  // first matching entry from the head
  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int k = DEPTH - 1; k >= 0; k--) begin
      if ((FILL_W'(k) < fill_r) && (val_r[k] == in_value)) begin
        hit_any = 1'b1;
        hit_idx = IDX_W'(k);
      end
    end
  end

  assign rd_idx  = cmd.dump ? dump_idx_r : hit_idx;
  assign rd_val  = val_r[rd_idx];
  assign rd_cnt  = cnt_r[rd_idx];
  assign rd_ord  = ord_r[rd_idx];
  assign cnt_inc = (rd_cnt == CNT_MAX) ? rd_cnt : rd_cnt + COUNT_BITS'(1);
  assign ord_sel = (rd_cnt == '0) ? next_ord_r[STAMP_W-1:0] : rd_ord;

  // landing slot: one past the last entry ahead of hit that the entry cannot pass
  always_comb begin
    dest = '0;
    for (int k = 0; k < DEPTH; k++) begin
      if ((IDX_W'(k) < hit_r) &&
          !((cnt_r[k] < cnt_new_r) ||
            ((cnt_r[k] == cnt_new_r) && (ord_r[k] > ord_new_r)))) begin
        dest = IDX_W'(k + 1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      unique case (op_r)
        OP_LOAD: begin
          if (!full) begin
            val_r[fill_r[IDX_W-1:0]] <= key_r;
            cnt_r[fill_r[IDX_W-1:0]] <= '0;
          end
        end
        OP_LOCATE: begin
          if (found_r) begin
            for (int j = 0; j < DEPTH; j++) begin
              if (IDX_W'(j) == dest) begin
                val_r[j] <= key_r;
                cnt_r[j] <= cnt_new_r;
                ord_r[j] <= ord_new_r;
              end
            end
            for (int j = 1; j < DEPTH; j++) begin
              if ((IDX_W'(j) > dest) && (IDX_W'(j) <= hit_r)) begin
                val_r[j] <= val_r[j-1];
                cnt_r[j] <= cnt_r[j-1];
                ord_r[j] <= ord_r[j-1];
              end
            end
          end
        end
        OP_DUMP: begin
        end
        OP_CLEAR: begin
        end
        default: begin
        end
      endcase
    end
  end

  // fill level and first-access stamp counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      next_ord_r <= '0;
    end else if (cmd.exec) begin
      if (op_r == OP_LOAD && !full) begin
        fill_r <= fill_r + FILL_W'(1);
      end else if (op_r == OP_CLEAR) begin
        fill_r     <= '0;
        next_ord_r <= '0;
      end
      if (op_r == OP_LOCATE && found_r && stamp_r && next_ord_r != ORD_MAX) begin
        next_ord_r <= next_ord_r + ORDER_W'(1);
      end
    end
  end

  // command capture and match results
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r       <= in_op;
      key_r      <= in_value;
      found_r    <= hit_any;
      hit_r      <= hit_idx;
      cnt_new_r  <= cnt_inc;
      ord_new_r  <= ord_sel;
      stamp_r    <= (rd_cnt == '0);
      dump_idx_r <= '0;
    end else if (cmd.dump) begin
      dump_idx_r <= dump_idx_r + IDX_W'(1);
    end
  end

  assign sts.dump_done = empty || ((FILL_W'(dump_idx_r) + FILL_W'(1)) == fill_r);

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.exec || cmd.dump;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      last_r <= 1'b1;
      unique case (op_r)
        OP_LOAD: begin
          status_r <= full ? ST_FULL : ST_OK;
          item_r   <= key_r;
          count_r  <= '0;
          pos_r    <= full ? '0 : POS_W'(fill_r[IDX_W-1:0]);
        end
        OP_LOCATE: begin
          item_r <= key_r;
          if (empty) begin
            status_r <= ST_EMPTY;
            count_r  <= '0;
            pos_r    <= '0;
          end else if (!found_r) begin
            status_r <= ST_NOT_FOUND;
            count_r  <= '0;
            pos_r    <= '0;
          end else begin
            status_r <= ST_OK;
            count_r  <= cnt_new_r;
            pos_r    <= POS_W'(dest);
          end
        end
        OP_DUMP, OP_CLEAR: begin
          status_r <= ST_OK;
          item_r   <= '0;
          count_r  <= '0;
          pos_r    <= '0;
        end
        default: begin
          status_r <= ST_OK;
          item_r   <= '0;
          count_r  <= '0;
          pos_r    <= '0;
        end
      endcase
    end else if (cmd.dump) begin
      last_r <= sts.dump_done;
      if (empty) begin
        status_r <= ST_EMPTY;
        item_r   <= '0;
        count_r  <= '0;
        pos_r    <= '0;
      end else begin
        status_r <= ST_OK;
        item_r   <= rd_val;
        count_r  <= rd_cnt;
        pos_r    <= POS_W'(dump_idx_r);
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_item_value   = item_r;
  assign out_access_count = count_r;
  assign out_position     = pos_r;
  assign out_last         = last_r;

endmodule
`default_nettype wire

// File: hdl/fol_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fol_checker
// Port-level timing and result-field checks for the frequency-ordered list core.
// ----------------------------------------------------------------------------
module fol_checker #(
  parameter int COUNT_BITS = fol_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  fol_pkg::op_t                  in_op,
  input  logic                          out_valid,
  input  fol_pkg::status_t              out_status,
  input  logic [COUNT_BITS-1:0]         out_access_count,
  input  logic [fol_pkg::POS_W-1:0]     out_position,
  input  logic                          out_last
);
  import fol_pkg::*;

  // a single-beat command answers with a final beat, registered after its execute state
  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_op != OP_DUMP) |=> ##1 (out_valid && out_last))
    else $error("single-beat command did not answer on time");

  // beats of one dump come back to back
  a_dump_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> out_valid)
    else $error("dump burst broken");

  // a refused load reports no count and no rank
  a_full_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |->
      (out_access_count == '0 && out_position == '0 && out_last))
    else $error("full status with nonzero fields");

  // a successful locate never reports a zero count
  a_locate_count: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_op == OP_LOCATE) |=> ##1
      (out_status != ST_OK || out_access_count != '0))
    else $error("located entry with zero count");

  // reset leaves the block idle with no beat
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid))
    else $error("not idle after reset");

endmodule

bind frequency_ordered_list_core fol_checker #(
  .COUNT_BITS (COUNT_BITS)
) u_fol_checker (.*);
`default_nettype wire
